>>> design/xalu_pkg.sv
// Package: shared types and codes for the x86 integer ALU.
`timescale 1ns / 1ps
package xalu_pkg;

    localparam int unsigned DataW = 32;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_ADC  = 5'd1,
        OP_SUB  = 5'd2,
        OP_SBB  = 5'd3,
        OP_MUL  = 5'd4,
        OP_IMUL = 5'd5,
        OP_DIV  = 5'd6,
        OP_IDIV = 5'd7,
        OP_MOD  = 5'd8,
        OP_IMOD = 5'd9,
        OP_AND  = 5'd10,
        OP_XOR  = 5'd11,
        OP_OR   = 5'd12,
        OP_SHL  = 5'd13,
        OP_SHR  = 5'd14,
        OP_SAR  = 5'd15,
        OP_SAL  = 5'd16
    } op_t;

    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;
    localparam logic [1:0] SZ_32 = 2'd2;

    typedef struct packed {
        logic [4:0]  mode;
        logic [31:0] source_operand;
        logic [31:0] dest_operand;
        logic [31:0] dest_high;
        logic [1:0]  size_code;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result_low;
        logic [31:0] result_high;
        logic        carry_flag;
        logic        parity_flag;
        logic        zero_flag;
        logic        sign_flag;
        logic        overflow_flag;
        logic        divide_error;
    } out_item_t;

    // Request and reply between sequencer and shift-add/subtract unit
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [31:0] opa;
        logic [31:0] opb;
        logic [31:0] hi;
        logic [5:0]  nbits;
    } iter_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] lo;
        logic [31:0] hw;
        logic        ovf;
    } iter_rsp_t;

endpackage

>>> design/xalu_iter.sv
// Iterative shift-add multiplier and restoring divider on unsigned magnitudes.
`timescale 1ns / 1ps
module xalu_iter (
    input  logic                clk,
    input  logic                rst_n,
    input  xalu_pkg::iter_req_t req,
    output xalu_pkg::iter_rsp_t rsp
);
    import xalu_pkg::*;

    localparam int unsigned DATA_W = DataW;
    localparam int unsigned CNT_W  = $clog2(DATA_W + 1);
    localparam int unsigned IDX_W  = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              div_reg, div_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W:0]   acc_reg, acc_next;     // running high half / remainder
    logic [DATA_W-1:0] q_reg, q_next;         // low half / quotient
    logic [DATA_W-1:0] b_reg, b_next;
    logic              ovf_reg, ovf_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   sum;
    logic [DATA_W+1:0] trial;
    logic [IDX_W-1:0]  bit_idx;

    // dividend bit consumed this step; its quotient bit lands in the same place
    assign bit_idx = IDX_W'(cnt_reg - 1'b1);

    // Step one bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        b_next    = b_reg;
        ovf_next  = ovf_reg;
        done_next = 1'b0;
        sum       = '0;
        trial     = '0;
        if (req.start)
        begin
            busy_next = 1'b1;
            div_next  = req.is_div;
            cnt_next  = req.nbits[CNT_W-1:0];
            b_next    = req.opb;
            q_next    = req.opa;
            acc_next  = req.is_div ? {1'b0, req.hi} : '0;
            // quotient fits only when high part is below divisor
            ovf_next  = req.is_div && (req.hi >= req.opb);
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                trial = {acc_reg, q_reg[bit_idx]} - {2'b0, b_reg};
                if (!trial[DATA_W+1])
                begin
                    acc_next        = trial[DATA_W:0];
                    q_next[bit_idx] = 1'b1;
                end
                else
                begin
                    acc_next        = {acc_reg[DATA_W-1:0], q_reg[bit_idx]};
                    q_next[bit_idx] = 1'b0;
                end
            end
            else
            begin
                sum      = q_reg[0] ? acc_reg + {1'b0, b_reg} : acc_reg;
                acc_next = {1'b0, sum[DATA_W:1]};
                q_next   = {sum[0], q_reg[DATA_W-1:1]};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        q_reg   <= q_next;
        b_reg   <= b_next;
        ovf_reg <= ovf_next;
    end

    assign rsp.done = done_reg;
    assign rsp.lo   = q_reg;
    assign rsp.hw   = acc_reg[DATA_W-1:0];
    assign rsp.ovf  = ovf_reg;

endmodule

>>> design/x86_integer_alu_with_flags.sv
// Top level: x86 integer ALU with stored status flags.
//
//  channel | direction | payload     | handshake
//  in      | input     | in_item_t   | in_valid / in_ready
//  out     | output    | out_item_t  | out_valid / out_ready
//
// One item at a time. Add, logic and shift items go from accept through EXEC to
// OUT. Multiply and divide start one shift-add/subtract unit in EXEC, which steps
// one bit per cycle while the sequencer waits in WAIT, then go to OUT.
// Reset clears the flags to zero and the sequencer to idle. A held result
// stalls the next accept until it is taken.
`timescale 1ns / 1ps
module x86_integer_alu_with_flags (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  xalu_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output xalu_pkg::out_item_t out_data
);
    import xalu_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    // flag bits: 0 CF, 1 PF, 2 ZF, 3 SF, 4 OF
    state_t      state_reg, state_next;
    logic [4:0]  flags_reg, flags_next;
    in_item_t    item_reg;
    out_item_t   res_reg, res_next;
    iter_req_t   req;
    iter_rsp_t   rsp;

    logic [5:0]  n;
    logic [31:0] mask, a, b, hi, sbit;
    logic        is_md, is_signed, is_mul;
    logic        a_neg, b_neg, d_neg;
    logic [31:0] ma, mb, mhi;
    logic [63:0] dd, dmag;

    // Operand decode for the registered item
    always_comb
    begin
        case (item_reg.size_code)
            SZ_8:    n = 6'd8;
            SZ_16:   n = 6'd16;
            default: n = 6'd32;
        endcase
        mask = 32'hFFFF_FFFF >> (6'd32 - n);
        sbit = 32'h1 << (n - 6'd1);
        a    = item_reg.dest_operand & mask;
        b    = item_reg.source_operand & mask;
        hi   = item_reg.dest_high & mask;
        is_mul    = (item_reg.mode == OP_MUL) || (item_reg.mode == OP_IMUL);
        is_signed = (item_reg.mode == OP_IMUL) || (item_reg.mode == OP_IDIV)
                    || (item_reg.mode == OP_IMOD);
        is_md     = is_mul || (item_reg.mode == OP_DIV) || (item_reg.mode == OP_IDIV)
                    || (item_reg.mode == OP_MOD) || (item_reg.mode == OP_IMOD);
        a_neg = is_signed && ((a & sbit) != '0) && is_mul;
        d_neg = is_signed && ((hi & sbit) != '0);
        b_neg = is_signed && ((b & sbit) != '0);
        mb    = b_neg ? ((~b + 32'd1) & mask) : b;
        // two-word magnitude of the dividend, split at the operand size
        dd    = ({32'h0, hi} << n) | {32'h0, a};
        dmag  = d_neg ? (64'h0 - dd) : dd;
        if (is_mul)
        begin
            ma  = a_neg ? ((~a + 32'd1) & mask) : a;
            mhi = '0;
        end
        else
        begin
            ma  = dmag[31:0] & mask;
            mhi = 32'(dmag >> n) & mask;
        end
    end

    // Start the shared unit
    always_comb
    begin
        req.start  = (state_reg == ST_EXEC) && is_md;
        req.is_div = !is_mul;
        req.opa    = ma;
        req.opb    = mb;
        req.hi     = mhi;
        req.nbits  = n;
    end

    xalu_iter u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    function automatic logic [2:0] szp(input logic [31:0] r, input logic [31:0] m,
                                       input logic [31:0] sb);
        szp = {(r & sb) != '0, (r & m) == '0, ~^r[7:0]};
    endfunction

    logic [32:0] s33;
    logic [31:0] r, rh, t, q, rem, shl_t;
    logic [63:0] p;
    logic        cb, q_neg, derr;
    logic [4:0]  c;

    // Compute result and next flags
    always_comb
    begin
        r = '0; rh = '0; derr = 1'b0; cb = 1'b0; s33 = '0; t = '0; shl_t = '0;
        p = '0; q = '0; rem = '0; q_neg = 1'b0;
        c = item_reg.source_operand[4:0];
        flags_next = flags_reg;
        case (item_reg.mode)
            OP_ADD, OP_ADC:
            begin
                s33 = {1'b0, a} + {1'b0, b} +
                      33'((item_reg.mode == OP_ADC) & flags_reg[0]);
                r = s33[31:0] & mask;
                flags_next[3:1] = szp(r, mask, sbit);
                flags_next[0] = ((s33 >> n) & 33'h1) != '0;
                flags_next[4] = ((a ^ r) & (b ^ r) & sbit) != '0;
            end
            OP_SUB, OP_SBB:
            begin
                s33 = {1'b0, a} - {1'b0, b} -
                      33'((item_reg.mode == OP_SBB) & flags_reg[0]);
                r = s33[31:0] & mask;
                flags_next[3:1] = szp(r, mask, sbit);
                flags_next[0] = n == 6'd32 ? s33[32] : ((s33 >> n) & 33'h1) != '0;
                flags_next[4] = ((a ^ b) & (a ^ r) & sbit) != '0;
            end
            OP_MUL, OP_IMUL:
            begin
                p = {rsp.hw, rsp.lo} >> (6'd32 - n);
                if (a_neg ^ b_neg)
                    p = ~p + 64'd1;
                r  = p[31:0] & mask;
                rh = 32'(p >> n) & mask;
                flags_next[3:1] = szp(r, mask, sbit);
                if (item_reg.mode == OP_MUL)
                    flags_next[0] = rh != '0;
                else
                    flags_next[0] = (rh != (((r & sbit) != '0) ? mask : 32'h0));
                flags_next[4] = flags_next[0];
            end
            OP_DIV, OP_MOD, OP_IDIV, OP_IMOD:
            begin
                q   = rsp.lo & mask;
                rem = rsp.hw & mask;
                q_neg = d_neg ^ b_neg;
                derr = (b == '0) || rsp.ovf ||
                       (is_signed && (q_neg ? (q > sbit) : (q >= sbit)));
                if (!derr)
                begin
                    if (item_reg.mode == OP_DIV || item_reg.mode == OP_IDIV)
                    begin
                        r = (q_neg ? (~q + 32'd1) : q) & mask;
                        flags_next[3:1] = szp(r, mask, sbit);
                        flags_next[0] = 1'b0;
                        flags_next[4] = 1'b0;
                    end
                    else
                    begin
                        r = (d_neg ? (~rem + 32'd1) : rem) & mask;
                    end
                end
            end
            OP_AND, OP_XOR, OP_OR:
            begin
                r = item_reg.mode == OP_AND ? (a & b) :
                    (item_reg.mode == OP_XOR ? (a ^ b) : (a | b));
                flags_next = {1'b0, szp(r, mask, sbit), 1'b0};
            end
            OP_SHL, OP_SAL, OP_SHR, OP_SAR:
            begin
                if (c == '0)
                    r = a;
                else
                begin
                    if (item_reg.mode == OP_SHL || item_reg.mode == OP_SAL)
                    begin
                        shl_t = a << (c - 5'd1);
                        cb = (shl_t & sbit) != '0;
                        r  = (shl_t << 1) & mask;
                        flags_next[3:1] = szp(r, mask, sbit);
                        flags_next[4] = (c == 5'd1) && (((r & sbit) != '0) ^ cb);
                    end
                    else if (item_reg.mode == OP_SHR)
                    begin
                        t  = a >> (c - 5'd1);
                        cb = t[0];
                        r  = t >> 1;
                        flags_next[3:1] = szp(r, mask, sbit);
                        flags_next[4] = (c == 5'd1) && ((a & sbit) != '0);
                    end
                    else
                    begin
                        t  = (((a & sbit) != '0) ? (a | ~mask) : a);
                        t  = $signed(t) >>> (c - 5'd1);
                        cb = t[0];
                        r  = 32'($signed(t) >>> 1) & mask;
                        flags_next[3:1] = szp(r, mask, sbit);
                        flags_next[4] = 1'b0;
                    end
                    flags_next[0] = cb;
                end
            end
            default:
            begin
                r = '0;
            end
        endcase
        if (derr)
        begin
            r = '0;
            rh = '0;
            flags_next = flags_reg;
        end
        res_next.result_low    = r;
        res_next.result_high   = rh;
        res_next.carry_flag    = flags_next[0];
        res_next.parity_flag   = flags_next[1];
        res_next.zero_flag     = flags_next[2];
        res_next.sign_flag     = flags_next[3];
        res_next.overflow_flag = flags_next[4];
        res_next.divide_error  = derr;
    end

    logic finish;
    assign finish = ((state_reg == ST_EXEC) && !is_md) ||
                    ((state_reg == ST_WAIT) && rsp.done);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_EXEC;
            ST_EXEC: state_next = is_md ? ST_WAIT : ST_OUT;
            ST_WAIT: if (rsp.done) state_next = ST_OUT;
            ST_OUT:  if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            flags_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
                flags_reg <= flags_next;
        end
    end

    // Hold item and result
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_data;
        if (finish)
            res_reg <= res_next;
    end

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = state_reg == ST_OUT;
    assign out_data  = res_reg;

`ifndef SYNTHESIS
    // divide error leaves the stored flags untouched
    a_derr_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && res_next.divide_error) |=> $stable(flags_reg))
        else $error("flags changed on divide error");

    // no accept while a result is pending
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("accept overlaps pending result");

    // a shown result holds until transferred
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result dropped before transfer");
`endif

endmodule

>>> tb/alu_checker.sv
// Checker: watches both channels, predicts ALU results and flags, compares.
`timescale 1ns / 1ps
module alu_checker
    import xalu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        fail_count,
    output int        pending
);

    out_item_t  expected_q[$];
    logic [4:0] flags_now;  // {OF, SF, ZF, PF, CF}

    function automatic logic [63:0] sext_word(input logic [63:0] v, input int w);
        logic [63:0] m;
        begin
            m = (64'd1 << w) - 64'd1;
            v = v & m;
            if (v[w-1])
                v = v | ~m;
            return v;
        end
    endfunction

    function automatic logic [4:0] szp_bits(input logic [63:0] r, input int n,
                                            input logic [31:0] mask);
        logic [4:0] f;
        begin
            f = '0;
            f[1] = ~^r[7:0];
            f[2] = ((r[31:0] & mask) == 32'd0);
            f[3] = r[n-1];
            return f;
        end
    endfunction

    // Compute the result of one transfer and advance the stored flags.
    function automatic out_item_t alu_predict(input in_item_t it);
        int         n;
        logic [31:0] mask;
        logic [63:0] a, b, hi, r, rh, s, p, dd, dv, md, mv, q, rem, lim, t, cin;
        logic [4:0] f;
        logic       derr, dneg, vneg, qneg, cbit;
        int         c;
        out_item_t  o;
        begin
            n = (it.size_code == SZ_8) ? 8 : (it.size_code == SZ_16) ? 16 : 32;
            mask = 32'hFFFFFFFF >> (32 - n);
            a = it.dest_operand & mask;
            b = it.source_operand & mask;
            hi = it.dest_high & mask;
            r = 0; rh = 0; f = flags_now; derr = 0;
            c = it.source_operand[4:0];
            case (it.mode)
                OP_ADD, OP_ADC:
                begin
                    cin = (it.mode == OP_ADC) ? flags_now[0] : 0;
                    s = a + b + cin;
                    r = s & mask;
                    f = szp_bits(r, n, mask);
                    f[0] = s[n];
                    f[4] = 1'(((a ^ r) & (b ^ r)) >> (n - 1));
                end
                OP_SUB, OP_SBB:
                begin
                    cin = (it.mode == OP_SBB) ? flags_now[0] : 0;
                    s = a - b - cin;
                    r = s & mask;
                    f = szp_bits(r, n, mask);
                    f[0] = s[n];
                    f[4] = 1'(((a ^ b) & (a ^ r)) >> (n - 1));
                end
                OP_MUL:
                begin
                    p = a * b;
                    r = p & mask;
                    rh = (p >> n) & mask;
                    f = szp_bits(r, n, mask);
                    f[0] = (rh != 0);
                    f[4] = (rh != 0);
                end
                OP_IMUL:
                begin
                    p = sext_word(a, n) * sext_word(b, n);
                    r = p & mask;
                    rh = (p >> n) & mask;
                    f = szp_bits(r, n, mask);
                    f[0] = (sext_word(r, n) != p);
                    f[4] = f[0];
                end
                OP_DIV, OP_MOD:
                begin
                    dd = (hi << n) | a;
                    if (b == 0)
                        derr = 1;
                    else
                    begin
                        q = dd / b;
                        rem = dd % b;
                        if (q > mask)
                            derr = 1;
                        else if (it.mode == OP_DIV)
                        begin
                            r = q;
                            f = szp_bits(r, n, mask);
                        end
                        else
                            r = rem;
                    end
                end
                OP_IDIV, OP_IMOD:
                begin
                    dd = sext_word((hi << n) | a, 2 * n);
                    dv = sext_word(b, n);
                    dneg = dd[63];
                    vneg = dv[63];
                    md = dneg ? -dd : dd;
                    mv = vneg ? -dv : dv;
                    lim = 64'd1 << (n - 1);
                    if (mv == 0)
                        derr = 1;
                    else
                    begin
                        q = md / mv;
                        rem = md % mv;
                        qneg = dneg != vneg;
                        if (qneg ? (q > lim) : (q > lim - 1))
                            derr = 1;
                        else if (it.mode == OP_IDIV)
                        begin
                            r = (qneg ? -q : q) & mask;
                            f = szp_bits(r, n, mask);
                        end
                        else
                            r = (dneg ? -rem : rem) & mask;
                    end
                end
                OP_AND, OP_XOR, OP_OR:
                begin
                    r = (it.mode == OP_AND) ? (a & b) : (it.mode == OP_XOR) ? (a ^ b) : (a | b);
                    f = szp_bits(r, n, mask);
                end
                OP_SHL, OP_SAL, OP_SHR, OP_SAR:
                begin
                    if (c == 0)
                        r = a;
                    else
                    begin
                        if (it.mode == OP_SHR)
                        begin
                            r = a >> c;
                            cbit = a[c-1];
                            f = szp_bits(r, n, mask);
                            f[4] = (c == 1) && a[n-1];
                        end
                        else if (it.mode == OP_SAR)
                        begin
                            s = sext_word(a, n);
                            r = ($signed(s) >>> c) & mask;
                            cbit = s[c-1];
                            f = szp_bits(r, n, mask);
                        end
                        else
                        begin
                            t = a << c;
                            r = t & mask;
                            cbit = t[n];
                            f = szp_bits(r, n, mask);
                            f[4] = (c == 1) && (r[n-1] ^ cbit);
                        end
                        f[0] = cbit;
                    end
                end
                default:
                    ;
            endcase
            if (derr)
            begin
                r = 0;
                rh = 0;
                f = flags_now;
            end
            flags_now = f;
            o.result_low = r[31:0];
            o.result_high = rh[31:0];
            o.carry_flag = f[0];
            o.parity_flag = f[1];
            o.zero_flag = f[2];
            o.sign_flag = f[3];
            o.overflow_flag = f[4];
            o.divide_error = derr;
            return o;
        end
    endfunction

    assign pending = expected_q.size();

    // Predict on input transfers, compare on output transfers.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            flags_now = '0;
            fail_count = 0;
            expected_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result %h", out_data);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (out_data.result_low !== e.result_low)
                    begin
                        $error("result_low exp %h got %h", e.result_low, out_data.result_low);
                        fail_count = fail_count + 1;
                    end
                    if (out_data.result_high !== e.result_high)
                    begin
                        $error("result_high exp %h got %h", e.result_high,
                               out_data.result_high);
                        fail_count = fail_count + 1;
                    end
                    if (out_data.carry_flag !== e.carry_flag)
                    begin
                        $error("carry_flag exp %b got %b", e.carry_flag, out_data.carry_flag);
                        fail_count = fail_count + 1;
                    end
                    if (out_data.parity_flag !== e.parity_flag)
                    begin
                        $error("parity_flag exp %b got %b", e.parity_flag,
                               out_data.parity_flag);
                        fail_count = fail_count + 1;
                    end
                    if (out_data.zero_flag !== e.zero_flag)
                    begin
                        $error("zero_flag exp %b got %b", e.zero_flag, out_data.zero_flag);
                        fail_count = fail_count + 1;
                    end
                    if (out_data.sign_flag !== e.sign_flag)
                    begin
                        $error("sign_flag exp %b got %b", e.sign_flag, out_data.sign_flag);
                        fail_count = fail_count + 1;
                    end
                    if (out_data.overflow_flag !== e.overflow_flag)
                    begin
                        $error("overflow_flag exp %b got %b", e.overflow_flag,
                               out_data.overflow_flag);
                        fail_count = fail_count + 1;
                    end
                    if (out_data.divide_error !== e.divide_error)
                    begin
                        $error("divide_error exp %b got %b", e.divide_error,
                               out_data.divide_error);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(alu_predict(in_data));
        end
    end

endmodule

>>> tb/testbench.sv
// Testbench top: drives ALU operations with random idling and gives the verdict.
`timescale 1ns / 1ps
module testbench;
    import xalu_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    int        fail_count;
    int        pending;
    int        send_idle_pct = 0;
    int        stall_pct = 0;

    always #6 clk = ~clk;

    x86_integer_alu_with_flags i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    alu_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // Stall the result side at random.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // Hold one transfer on the input until accepted, with random idle gaps ahead.
    task automatic send_op(input logic [4:0] mode, input logic [31:0] src,
                           input logic [31:0] dst, input logic [31:0] dhi,
                           input logic [1:0] sz);
        logic idle;
        begin
            idle = ($urandom_range(99) < send_idle_pct);
            if (idle)
                in_valid <= 1'b0;
            while (idle)
            begin
                @(posedge clk);
                idle = ($urandom_range(99) < send_idle_pct);
            end
            in_data <= '{mode: mode, source_operand: src, dest_operand: dst,
                         dest_high: dhi, size_code: sz};
            in_valid <= 1'b1;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFFFFFF;
            2: return $urandom_range(3);
            3: return 32'h80000000 >> ($urandom_range(3) * 8);
            default: return $urandom;
        endcase
    endfunction

    // Division: high word mostly all zeros or all ones, so many quotients fit.
    task automatic random_op();
        logic [4:0]  mode;
        logic [31:0] src, dst, dhi;
        logic [1:0]  sz;
        begin
            mode = ($urandom_range(49) == 0) ? 5'($urandom_range(31, 17))
                                             : 5'($urandom_range(16));
            sz = 2'($urandom_range(3));
            src = rand_value();
            dst = rand_value();
            dhi = rand_value();
            if ($urandom_range(3) != 0)
                dhi = $urandom_range(1) ? 32'd0 : 32'hFFFFFFFF;
            if (mode >= OP_SHL && $urandom_range(1))
                src = {$urandom_range(1) ? 27'h7FFFFFF : 27'd0, 5'($urandom_range(31))};
            send_op(mode, src, dst, dhi, sz);
        end
    endtask

    initial
    begin
        #10_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        int phase;
        int k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every operation, shift and divide corners.
        send_op(OP_ADD, 32'hFFFFFFFF, 32'h1, 0, SZ_32);
        send_op(OP_ADC, 32'h7F, 32'h0, 0, SZ_8);
        send_op(OP_SUB, 32'h1, 32'h0, 0, SZ_16);
        send_op(OP_SBB, 32'h0, 32'h80000000, 0, SZ_32);
        send_op(OP_MUL, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, SZ_32);
        send_op(OP_IMUL, 32'h80, 32'h80, 0, SZ_8);
        send_op(OP_DIV, 32'd0, 32'd5, 0, SZ_16);
        send_op(OP_DIV, 32'd1, 32'd5, 32'd1, SZ_8);
        send_op(OP_IDIV, 32'hFF, 32'h80, 32'hFF, SZ_8);
        send_op(OP_IDIV, 32'hFF, 32'h81, 32'hFF, SZ_8);
        send_op(OP_MOD, 32'd7, 32'hFFFFFFFF, 32'd6, SZ_32);
        send_op(OP_IMOD, 32'd3, 32'hFFFFFFF9, 32'hFFFFFFFF, SZ_32);
        send_op(OP_AND, 32'hFFFFFFFF, 32'hA5A5A5A5, 0, 2'd3);
        send_op(OP_XOR, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, SZ_16);
        send_op(OP_OR, 32'h0, 32'h0, 0, SZ_8);
        send_op(OP_SHL, 32'd0, 32'h81, 0, SZ_8);
        send_op(OP_SHL, 32'd1, 32'h81, 0, SZ_8);
        send_op(OP_SAL, 32'd9, 32'hFF, 0, SZ_8);
        send_op(OP_SHR, 32'd1, 32'h8001, 0, SZ_16);
        send_op(OP_SHR, 32'd31, 32'hFFFF, 0, SZ_16);
        send_op(OP_SAR, 32'd20, 32'h80, 0, SZ_8);
        send_op(OP_SAR, 32'hFFFFFFE1, 32'h80000001, 0, SZ_32);
        send_op(5'd31, 32'h1, 32'h1, 0, SZ_8);

        // Random phases: no idling, sender idle, receiver stall, both.
        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 85 : 29) : 0;
            stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 85 : 29) : 0;
            for (k = 0; k < 420; k++)
                random_op();
            // Drop valid and let every pending result drain before the next phase.
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
        end

        stall_pct = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
